[hw/rtl/stq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and defaults of the sorted timeout queue: operation and status
// codes, and the shift command that the top level broadcasts to every cell.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TIME_BITS   = 48;
  localparam int DEF_HANDLE_BITS = 16;

  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 3;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FIRED     = 3'd3,
    ST_NOTHING   = 3'd4
  } status_t;

  // Broadcast to all cells for one beat.
  typedef struct packed {
    logic ins_en;  // insert into a queue that is not full
    logic del_en;  // delete by handle (cells from the first match onward shift)
    logic pop_en;  // tick fired: everything moves one place toward the head
  } stq_shift_t;

endpackage

[hw/rtl/sorted_timeout_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timeout_queue_top
// Bounded queue of pending timeouts kept in deadline order, built as a row
// of shift cells.
// ----------------------------------------------------------------------------
// Each input beat is one operation: insert (deadline, handle), delete by
// handle, or tick with the current time. Every beat yields exactly one result
// beat in the cycle after it is accepted, carrying the status, the fired handle
// (zero unless a timeout fired) and the number of entries left. One operation
// completes per cycle: all cells compare against the broadcast operands at
// once and move in the same edge, so a new beat is taken whenever the result
// register is empty or being drained. The longest path is the handle match
// that ripples through the row of cells to find the first matching entry on
// delete. Entries with equal deadlines leave in arrival order.
// ----------------------------------------------------------------------------
module sorted_timeout_queue_top #(
  parameter int QUEUE_DEPTH = stq_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_BITS   = stq_pkg::DEF_TIME_BITS,
  parameter int HANDLE_BITS = stq_pkg::DEF_HANDLE_BITS,
  parameter int CountBits   = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [stq_pkg::OP_BITS-1:0] operation,
  input  logic [TIME_BITS-1:0]       deadline,
  input  logic [HANDLE_BITS-1:0]     handle_id,
  input  logic [TIME_BITS-1:0]       current_time,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [stq_pkg::STATUS_BITS-1:0] status,
  output logic [HANDLE_BITS-1:0]     fired_handle,
  output logic [CountBits-1:0]       entries_left
);
  import stq_pkg::*;

  // Occupancy and result register.
  logic [CountBits-1:0]   count;
  logic [CountBits-1:0]   count_next;
  status_t                status_reg;
  status_t                status_next;
  logic [HANDLE_BITS-1:0] fired_next;

  logic       accept;
  logic       full;
  logic       found;
  logic       due;
  stq_shift_t shift;

  // Cell row wiring.
  logic                   cell_place    [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]   cell_deadline [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] cell_handle   [QUEUE_DEPTH];
  logic                   seen          [QUEUE_DEPTH+1];

  // Take a new beat when the result slot is free or drains this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign full  = count == CountBits'(QUEUE_DEPTH);
  assign found = seen[QUEUE_DEPTH];
  // Head entry is due once the current time has reached its deadline.
  assign due   = (count != '0) && (current_time >= cell_deadline[0]);

  assign seen[0] = 1'b0;

  always_comb begin
    shift       = '0;
    count_next  = count;
    status_next = ST_DONE;
    fired_next  = '0;
    case (op_t'(operation))
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          shift.ins_en = accept;
          count_next   = count + CountBits'(1);
        end
      end
      OP_DELETE: begin
        shift.del_en = accept;
        if (found) begin
          count_next = count - CountBits'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_TICK: begin
        if (due) begin
          shift.pop_en = accept;
          status_next  = ST_FIRED;
          fired_next   = cell_handle[0];
          count_next   = count - CountBits'(1);
        end else begin
          status_next = ST_NOTHING;
        end
      end
      default: begin
        // Unused code: report done, leave the queue alone.
        status_next = ST_DONE;
      end
    endcase
  end

  // The row of cells; index 0 holds the earliest deadline.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                   lp;
    logic [TIME_BITS-1:0]   ld;
    logic [HANDLE_BITS-1:0] lh;
    logic [TIME_BITS-1:0]   rd;
    logic [HANDLE_BITS-1:0] rh;

    if (i == 0) begin : g_head
      assign lp = 1'b0;
      assign ld = deadline;
      assign lh = handle_id;
    end else begin : g_mid
      assign lp = cell_place[i-1];
      assign ld = cell_deadline[i-1];
      assign lh = cell_handle[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      // Last slot becomes unoccupied after a shift toward the head.
      assign rd = cell_deadline[i];
      assign rh = cell_handle[i];
    end else begin : g_body
      assign rd = cell_deadline[i+1];
      assign rh = cell_handle[i+1];
    end

    stq_cell #(
      .TIME_BITS   (TIME_BITS),
      .HANDLE_BITS (HANDLE_BITS),
      .COUNT_BITS  (CountBits),
      .INDEX       (i)
    ) u_cell (
      .clk            (clk),
      .shift          (shift),
      .count          (count),
      .new_deadline   (deadline),
      .new_handle     (handle_id),
      .left_place     (lp),
      .left_deadline  (ld),
      .left_handle    (lh),
      .right_deadline (rd),
      .right_handle   (rh),
      .seen_in        (seen[i]),
      .place          (cell_place[i]),
      .seen_out       (seen[i+1]),
      .deadline       (cell_deadline[i]),
      .handle         (cell_handle[i])
    );
  end

  // Hold occupancy and the result beat; advance on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      status_reg   <= status_next;
      fired_handle <= fired_next;
      entries_left <= count_next;
    end
  end

  assign status = status_reg;

endmodule

[hw/rtl/stq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted queue. Holds a deadline and handle; on insert it
// holds, takes the new entry or takes its left neighbor; on pop, and on
// delete from the first matching slot onward, it takes its right neighbor.
// ----------------------------------------------------------------------------
module stq_cell #(
  parameter int TIME_BITS   = 48,
  parameter int HANDLE_BITS = 16,
  parameter int COUNT_BITS  = 5,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  stq_pkg::stq_shift_t    shift,
  input  logic [COUNT_BITS-1:0]  count,
  input  logic [TIME_BITS-1:0]   new_deadline,
  input  logic [HANDLE_BITS-1:0] new_handle,
  input  logic                   left_place,
  input  logic [TIME_BITS-1:0]   left_deadline,
  input  logic [HANDLE_BITS-1:0] left_handle,
  input  logic [TIME_BITS-1:0]   right_deadline,
  input  logic [HANDLE_BITS-1:0] right_handle,
  input  logic                   seen_in,
  output logic                   place,
  output logic                   seen_out,
  output logic [TIME_BITS-1:0]   deadline,
  output logic [HANDLE_BITS-1:0] handle
);
  import stq_pkg::*;

  logic                   occupied;
  logic [TIME_BITS-1:0]   deadline_next;
  logic [HANDLE_BITS-1:0] handle_next;

  assign occupied = count > COUNT_BITS'(INDEX);
  // New entry belongs here or earlier: slot empty or strictly later deadline.
  assign place    = !occupied || (deadline > new_deadline);
  assign seen_out = seen_in || (occupied && (handle == new_handle));

  always_comb begin
    deadline_next = deadline;
    handle_next   = handle;
    if (shift.ins_en) begin
      if (left_place) begin
        deadline_next = left_deadline;
        handle_next   = left_handle;
      end else if (place) begin
        deadline_next = new_deadline;
        handle_next   = new_handle;
      end
    end else if (shift.pop_en || (shift.del_en && seen_out)) begin
      deadline_next = right_deadline;
      handle_next   = right_handle;
    end
  end

  always_ff @(posedge clk) begin
    deadline <= deadline_next;
    handle   <= handle_next;
  end

endmodule

[tb/sorted_timeout_queue_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timeout_queue_top_test
// Self-checking bench for the sorted timeout queue: directed table, then a
// long random run. Each beat is checked against the table's outcome, if any,
// else a behavioral copy of the queue, under random stalls on both channels.
// ----------------------------------------------------------------------------
module sorted_timeout_queue_top_test;
  import stq_pkg::*;

  localparam int QD = DEF_QUEUE_DEPTH;
  localparam int TB_TIME_BITS = DEF_TIME_BITS;
  localparam int TB_HANDLE_BITS = DEF_HANDLE_BITS;
  localparam int LEFT_BITS = $clog2(QD + 1);

  // Operation code that the block must ignore.
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  localparam logic [TB_TIME_BITS-1:0] TIME_MAX = {TB_TIME_BITS{1'b1}};
  localparam logic [TB_HANDLE_BITS-1:0] HANDLE_MAX = {TB_HANDLE_BITS{1'b1}};

  localparam int RANDOM_ITEMS = 1250;
  localparam int QUIET_ITEMS = 100;    // tail of the run with no idling
  localparam int STALL_LIMIT = 2000;   // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 10;

  // One result beat as seen on the output ports.
  typedef struct packed {
    status_t status;
    logic [TB_HANDLE_BITS-1:0] fired;
    logic [LEFT_BITS-1:0] left;
  } outcome_t;

  // One row of the directed table. Rows with known set carry a typed outcome.
  typedef struct {
    logic [OP_BITS-1:0] op;
    logic [TB_TIME_BITS-1:0] dl;
    logic [TB_HANDLE_BITS-1:0] hid;
    logic [TB_TIME_BITS-1:0] now;
    bit known;
    outcome_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [OP_BITS-1:0] operation;
  logic [TB_TIME_BITS-1:0] deadline;
  logic [TB_HANDLE_BITS-1:0] handle_id;
  logic [TB_TIME_BITS-1:0] current_time;
  logic out_valid;
  logic out_ready;
  logic [STATUS_BITS-1:0] status;
  logic [TB_HANDLE_BITS-1:0] fired_handle;
  logic [LEFT_BITS-1:0] entries_left;

  // Typed outcome riding along with the beat on the input side.
  bit row_known;
  outcome_t row_want;

  // Behavioral copy of the queue: earliest deadline at index 0.
  logic [TB_TIME_BITS-1:0] pend_deadline [QD];
  logic [TB_HANDLE_BITS-1:0] pend_handle [QD];
  int pend_count;

  outcome_t due_results[$];
  plan_row_t plan[$];
  int fail_count;
  int stall_cycles;
  bit quiet_tail;

  sorted_timeout_queue_top #(
    .QUEUE_DEPTH(QD),
    .TIME_BITS(TB_TIME_BITS),
    .HANDLE_BITS(TB_HANDLE_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .deadline(deadline),
    .handle_id(handle_id),
    .current_time(current_time),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .fired_handle(fired_handle),
    .entries_left(entries_left)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Queue predictor
  // --------------------------------------------------------------------------

  // Drop the entry at pos and close the gap toward the head.
  task automatic pend_remove_at(input int pos);
    int i;
    for (i = pos; i + 1 < pend_count; i++) begin
      pend_deadline[i] = pend_deadline[i + 1];
      pend_handle[i] = pend_handle[i + 1];
    end
    pend_count--;
  endtask

  // Apply one operation to the copy and return the beat it should produce.
  task automatic apply_timer_op(input logic [OP_BITS-1:0] op,
                                input logic [TB_TIME_BITS-1:0] dl,
                                input logic [TB_HANDLE_BITS-1:0] hid,
                                input logic [TB_TIME_BITS-1:0] now,
                                output outcome_t res);
    int pos;
    int i;
    bit hit;
    res = '0;
    res.status = ST_DONE;
    case (op)
      OP_INSERT: begin
        if (pend_count >= QD) begin
          res.status = ST_FULL;
        end else begin
          // Go past every entry that is not later, so ties stay in order.
          pos = 0;
          while (pos < pend_count && pend_deadline[pos] <= dl) pos++;
          for (i = pend_count; i > pos; i--) begin
            pend_deadline[i] = pend_deadline[i - 1];
            pend_handle[i] = pend_handle[i - 1];
          end
          pend_deadline[pos] = dl;
          pend_handle[pos] = hid;
          pend_count++;
        end
      end
      OP_DELETE: begin
        hit = 1'b0;
        for (i = 0; i < pend_count && !hit; i++) begin
          if (pend_handle[i] == hid) begin
            pend_remove_at(i);
            hit = 1'b1;
          end
        end
        if (!hit) res.status = ST_NOT_FOUND;
      end
      OP_TICK: begin
        if (pend_count == 0 || now < pend_deadline[0]) begin
          res.status = ST_NOTHING;
        end else begin
          res.status = ST_FIRED;
          res.fired = pend_handle[0];
          pend_remove_at(0);
        end
      end
      default: begin
        // Unused code: leave the queue alone.
      end
    endcase
    res.left = LEFT_BITS'(pend_count);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("tb: mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_field(input string what, input longint got, input longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Sample both channels at the rising edge: predict on an input beat,
  // compare on an output beat against the oldest outcome waiting.
  always @(posedge clk) begin : monitor
    outcome_t res;
    outcome_t oldest;
    if (!rst) begin
      if (in_valid && in_ready) begin
        apply_timer_op(operation, deadline, handle_id, current_time, res);
        if (row_known) res = row_want;
        due_results.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result beat, status", status, 0);
        end else begin
          oldest = due_results.pop_front();
          check_field("status", status, oldest.status);
          check_field("fired_handle", fired_handle, oldest.fired);
          check_field("entries_left", entries_left, oldest.left);
        end
      end
    end
  end

  // End the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: hold ready low in random bursts, none at the tail
  // --------------------------------------------------------------------------
  initial begin : sink
    int run_left;
    bit run_low;
    out_ready = 1'b0;
    run_left = 0;
    run_low = 1'b0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        run_low = !quiet_tail && ($urandom_range(0, 3) == 0);
        run_left = run_low ? $urandom_range(1, 19) : $urandom_range(1, 40);
      end
      run_left--;
      out_ready <= !run_low;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  function automatic plan_row_t plan_row(input logic [OP_BITS-1:0] op,
                                         input logic [TB_TIME_BITS-1:0] dl,
                                         input logic [TB_HANDLE_BITS-1:0] hid,
                                         input logic [TB_TIME_BITS-1:0] now,
                                         input bit known,
                                         input status_t st,
                                         input logic [TB_HANDLE_BITS-1:0] fired,
                                         input int left);
    plan_row_t r;
    r.op = op;
    r.dl = dl;
    r.hid = hid;
    r.now = now;
    r.known = known;
    r.want.status = st;
    r.want.fired = fired;
    r.want.left = LEFT_BITS'(left);
    return r;
  endfunction

  function automatic logic [TB_TIME_BITS-1:0] rand_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TB_TIME_BITS-1:0];
  endfunction

  // Present one beat, starting at a falling edge, with an optional idle gap.
  // Return at the falling edge after the beat is taken, valid still high.
  task automatic send_beat(input plan_row_t r, input int idle_pct);
    if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    operation <= r.op;
    deadline <= r.dl;
    handle_id <= r.hid;
    current_time <= r.now;
    row_known <= r.known;
    row_want <= r.want;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin : driver
    plan_row_t r;
    logic [TB_TIME_BITS-1:0] sim_now;
    int idle_pct;
    int insert_pct;
    int n;
    int roll;

    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_INSERT;
    deadline = '0;
    handle_id = '0;
    current_time = '0;
    row_known = 1'b0;
    row_want = '0;
    pend_count = 0;
    fail_count = 0;
    stall_cycles = 0;
    quiet_tail = 1'b0;

    // Directed table: empty queue cases, extremes of time and handle, ties,
    // then fill to full and hit the full and absent-handle cases.
    plan.push_back(plan_row(OP_TICK, '0, '0, '0, 1, ST_NOTHING, '0, 0));
    plan.push_back(plan_row(OP_DELETE, '0, '0, '0, 1, ST_NOT_FOUND, '0, 0));
    plan.push_back(plan_row(OP_UNUSED, TIME_MAX, HANDLE_MAX, TIME_MAX, 1, ST_DONE, '0, 0));
    plan.push_back(plan_row(OP_INSERT, TIME_MAX, HANDLE_MAX, '0, 1, ST_DONE, '0, 1));
    plan.push_back(plan_row(OP_INSERT, '0, '0, TIME_MAX, 1, ST_DONE, '0, 2));
    plan.push_back(plan_row(OP_TICK, TIME_MAX, HANDLE_MAX, '0, 1, ST_FIRED, '0, 1));
    plan.push_back(plan_row(OP_TICK, '0, '0, TIME_MAX - 1, 1, ST_NOTHING, '0, 1));
    plan.push_back(plan_row(OP_TICK, '0, '0, TIME_MAX, 1, ST_FIRED, HANDLE_MAX, 0));
    // Groups of three equal deadlines, later groups earlier in time, with
    // repeated handles so delete has to pick the first match.
    for (n = 0; n < QD; n++) begin
      plan.push_back(plan_row(OP_INSERT, TB_TIME_BITS'(1000 - (n / 3) * 100),
                              TB_HANDLE_BITS'(16'h8000 | (n % 6)), '0,
                              0, ST_DONE, '0, 0));
    end
    plan.push_back(plan_row(OP_INSERT, 48'd10, 16'h1234, '0, 1, ST_FULL, '0, QD));
    plan.push_back(plan_row(OP_DELETE, '0, 16'hbeef, '0, 1, ST_NOT_FOUND, '0, QD));

    // Hold reset, then release it at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) send_beat(plan[i], 20);

    // Random run: time walks forward, inserts land a little ahead of it and
    // ticks catch up. The insert share swings between phases so the queue
    // both fills and drains; a tenth of the beats are unstructured noise.
    sim_now = 48'd500;
    idle_pct = 20;
    insert_pct = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        insert_pct = $urandom_range(15, 85);
        idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
      end
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      r = plan_row(OP_INSERT, '0, '0, '0, 0, ST_DONE, '0, 0);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        r.op = OP_BITS'($urandom_range(0, 3));
        r.dl = rand_time();
        r.hid = TB_HANDLE_BITS'($urandom);
        r.now = rand_time();
      end else if ($urandom_range(0, 99) < insert_pct) begin
        r.op = OP_INSERT;
        r.dl = sim_now + TB_TIME_BITS'($urandom_range(0, 300));
        r.hid = ($urandom_range(0, 4) == 0) ? TB_HANDLE_BITS'($urandom)
                                            : TB_HANDLE_BITS'($urandom_range(0, 31));
        r.now = rand_time();
      end else if ($urandom_range(0, 99) < 65) begin
        r.op = OP_TICK;
        sim_now = sim_now + TB_TIME_BITS'($urandom_range(0, 40));
        r.now = sim_now;
        r.dl = rand_time();
        r.hid = TB_HANDLE_BITS'($urandom);
      end else begin
        r.op = OP_DELETE;
        // Mostly aim at a pending handle; otherwise a likely miss.
        if (pend_count > 0 && $urandom_range(0, 3) != 0)
          r.hid = pend_handle[$urandom_range(0, pend_count - 1)];
        else
          r.hid = TB_HANDLE_BITS'($urandom_range(0, 63));
        r.dl = rand_time();
        r.now = rand_time();
      end
      send_beat(r, idle_pct);
    end
    in_valid <= 1'b0;

    // Drain: wait for every outcome, then let the output settle.
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/stq_pkg.sv
hw/rtl/stq_cell.sv
hw/rtl/sorted_timeout_queue_top.sv
tb/sorted_timeout_queue_top_test.sv
